// ===== hdl/irlc_pkg.sv =====
// Shared types and command codes for the interval record cache.
package irlc_pkg;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_INSTALL = 1'b1;

  localparam int SLOT_W = 16 + 24 + 64 + 63;

  typedef struct packed {
    logic [62:0] half;
    logic [63:0] mid;
    logic [23:0] rec;
    logic [15:0] seg;
  } slot_t;

  typedef struct packed {
    logic [23:0] rec;
    logic [15:0] seg;
    logic        hit;
  } result_t;

  // Exact closed-interval containment test on signed times.
  function automatic logic covers(input logic [63:0] t, input logic [63:0] mid,
                                  input logic [62:0] half);
    logic [63:0] gap;
    begin
      if ($signed(t) >= $signed(mid)) gap = t - mid;
      else gap = mid - t;
      covers = (gap <= {1'b0, half});
    end
  endfunction

endpackage

// ===== hdl/interval_record_lru_cache.sv =====
// Top level of the two-level interval record cache with its sequencer.
//
//  Channel | Ports                          | Contents
//  input   | in_tvalid/in_tready/in_tdata   | command, body, times, fill record
//  result  | out_tvalid/out_tready/out_tdata| hit, segment, record
//
// The tag scan, the slot scan and the list shift each walk one entry a cycle
// through the RAM read ports.
// Reset is synchronous and clears only the sequencer and the in-use counts.
// The block is not ready while a command is at work or a result waits.
module interval_record_lru_cache #(
  parameter int BODY_ENTRIES   = 16,
  parameter int SLOTS_PER_BODY = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[0], body_id[32:1], query_time[96:33], fill_segment[112:97],
  // fill_record[136:113], fill_mid[200:137], fill_half[263:201]
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit[0], segment_handle[16:1], record_index[40:17], zero fill
  output logic [47:0]  out_tdata
);
  import irlc_pkg::*;

  localparam int BW  = (BODY_ENTRIES > 1) ? $clog2(BODY_ENTRIES) : 1;
  localparam int SW  = (SLOTS_PER_BODY > 1) ? $clog2(SLOTS_PER_BODY) : 1;
  localparam int BCW = $clog2(BODY_ENTRIES + 1);
  localparam int SCW = $clog2(SLOTS_PER_BODY + 1);
  localparam int AW  = BW + SW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAG   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]     state_r, state_nxt;
  logic           cmd_r;
  logic [31:0]    tag_r;
  logic [63:0]    qt_r;
  slot_t          fill_r;
  logic [BCW-1:0] bodies_r;
  logic [SCW-1:0] cnt_r [BODY_ENTRIES];
  logic [BW-1:0]  body_r;
  logic [BCW-1:0] tidx_r;    // next tag to read
  logic [BW-1:0]  chk_r;     // tag entry on the read port
  logic [SCW-1:0] idx_r;     // scan index or shift position
  logic [SW-1:0]  pos_r;     // slot on the read port during the scan
  logic           pend_r;    // a read was issued last cycle
  logic [SW-1:0]  dst_r;
  result_t        res_r;

  // Body tag RAM.
  logic          tg_we;
  logic [BW-1:0] tg_wa, tg_ra;
  logic [31:0]   tg_rd;
  irlc_ram #(.WIDTH(32), .DEPTH(1 << BW)) u_tags (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tag_r), .raddr(tg_ra), .rdata(tg_rd));

  // Slot RAM, addressed by body and slot.
  logic          sl_we;
  logic [AW-1:0] sl_wa, sl_ra;
  slot_t         sl_wd, sl_rd;
  irlc_ram #(.WIDTH(SLOT_W), .DEPTH(1 << AW)) u_slots (
    .clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd));

  logic           tag_found, tag_alloc, scan_hit, scan_end;
  logic [BW-1:0]  alloc_idx;
  logic [SCW-1:0] n_cur, n_found, top_found, shift_src;

  assign n_cur     = cnt_r[body_r];
  assign n_found   = cnt_r[chk_r];
  // An install shifts the list down to the new count minus one.
  assign top_found = (n_found < SCW'(SLOTS_PER_BODY)) ? n_found
                                                      : SCW'(SLOTS_PER_BODY - 1);
  assign shift_src = idx_r - SCW'(1);
  assign tag_found = pend_r && (tg_rd == tag_r);
  assign tag_alloc = !tag_found && (tidx_r >= bodies_r);
  assign alloc_idx = (bodies_r >= BCW'(BODY_ENTRIES)) ? BW'(BODY_ENTRIES - 1)
                                                      : bodies_r[BW-1:0];
  assign scan_hit  = pend_r && covers(qt_r, sl_rd.mid, sl_rd.half);
  assign scan_end  = (idx_r >= n_cur);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, res_r};

  always_comb begin
    state_nxt = state_r;
    tg_we = 1'b0;
    tg_wa = alloc_idx;
    tg_ra = tidx_r[BW-1:0];
    sl_we = 1'b0;
    sl_wa = {body_r, dst_r};
    sl_wd = sl_rd;
    sl_ra = {body_r, idx_r[SW-1:0]};
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_TAG;
      S_TAG: begin
        if (tag_found) begin
          state_nxt = cmd_r ? S_SHIFT : S_SCAN;
        end else if (tag_alloc) begin
          tg_we = 1'b1;
          state_nxt = cmd_r ? S_PUT : S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_hit) state_nxt = S_SHIFT;
        else if (scan_end) state_nxt = S_OUT;
      end
      S_SHIFT: begin
        // Read slot idx-1 now; it lands in slot idx on the next cycle.
        sl_ra = {body_r, shift_src[SW-1:0]};
        sl_we = pend_r;
        if (idx_r == '0) state_nxt = S_PUT;
      end
      S_PUT: begin
        sl_we = 1'b1;
        sl_wa = {body_r, {SW{1'b0}}};
        sl_wd = fill_r;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bodies_r <= '0;
      pend_r   <= 1'b0;
      for (int i = 0; i < BODY_ENTRIES; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r       <= in_tdata[0];
          tag_r       <= in_tdata[32:1];
          qt_r        <= in_tdata[96:33];
          fill_r.seg  <= in_tdata[112:97];
          fill_r.rec  <= in_tdata[136:113];
          fill_r.mid  <= in_tdata[200:137];
          fill_r.half <= in_tdata[263:201];
          tidx_r      <= '0;
          pend_r      <= 1'b0;
          res_r       <= '0;
        end
        S_TAG: begin
          if (tag_found) begin
            body_r <= chk_r;
            pend_r <= 1'b0;
            idx_r  <= cmd_r ? top_found : '0;
          end else if (tag_alloc) begin
            // Allocate a new entry, or take over the last when full.
            body_r <= alloc_idx;
            cnt_r[alloc_idx] <= '0;
            if (bodies_r < BCW'(BODY_ENTRIES)) bodies_r <= bodies_r + BCW'(1);
            pend_r <= 1'b0;
            idx_r  <= '0;
          end else begin
            chk_r  <= tidx_r[BW-1:0];
            tidx_r <= tidx_r + BCW'(1);
            pend_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            res_r  <= '{rec: sl_rd.rec, seg: sl_rd.seg, hit: 1'b1};
            fill_r <= sl_rd;
            pend_r <= 1'b0;
            idx_r  <= SCW'(pos_r);
          end else if (scan_end) begin
            pend_r <= 1'b0;
          end else begin
            pos_r  <= idx_r[SW-1:0];
            idx_r  <= idx_r + SCW'(1);
            pend_r <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (idx_r == '0) begin
            pend_r <= 1'b0;
          end else begin
            dst_r  <= idx_r[SW-1:0];
            idx_r  <= shift_src;
            pend_r <= 1'b1;
          end
        end
        S_PUT: if (cmd_r) begin
          res_r <= '{rec: fill_r.rec, seg: fill_r.seg, hit: 1'b0};
          if (n_cur < SCW'(SLOTS_PER_BODY)) cnt_r[body_r] <= n_cur + SCW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/irlc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module irlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/irlc_checker.sv =====
// Port-level assertions for the interval record cache, bound to the top level.
module irlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while a result waits");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready right after a transfer");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && out_tdata[47:41] != 7'd0 |-> 1'b0)
    else $error("fill bits set");
endmodule

bind interval_record_lru_cache irlc_checker u_chk (.*);

// ===== tb/tb_interval_record_lru_cache.sv =====
// Self-checking testbench for the two-level interval record cache.
module tb_interval_record_lru_cache;
  import irlc_pkg::*;

  localparam int NBODY = 16;
  localparam int NSLOT = 8;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        cmd;
    logic [31:0] body;
    logic [63:0] qtime;
    logic [15:0] seg;
    logic [23:0] rec;
    logic [63:0] mid;
    logic [62:0] half;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] seg;
    logic [23:0] rec;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [263:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;

  interval_record_lru_cache dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: body table and per-body most-recent-first record lists.
  logic [31:0] tag_tab [NBODY];
  int          n_bodies;
  int          n_slots [NBODY];
  slot_t       lists [NBODY][NSLOT];

  answer_t expected_answers[$];
  int      errors;
  int      n_hits, n_installs, n_lookups, n_answers;
  longint  cycles;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h (answer %0d)", what, got, want, n_answers);
    errors++;
  endtask

  function automatic logic in_range(input logic [63:0] t, input logic [63:0] m,
                                    input logic [62:0] h);
    logic [64:0] d;
    d = $signed({t[63], t}) - $signed({m[63], m});
    if (d[64]) d = -d;
    return d <= {2'b0, h};
  endfunction

  function automatic answer_t predict_cache(input request_t r);
    answer_t a;
    int      b, n;
    slot_t   s;
    b = -1;
    a = '{1'b0, 16'h0, 24'h0};
    for (int i = 0; i < n_bodies; i++)
      if (b < 0 && tag_tab[i] == r.body) b = i;
    if (b < 0) begin
      if (n_bodies >= NBODY) b = NBODY - 1;
      else begin
        b = n_bodies;
        n_bodies++;
      end
      tag_tab[b] = r.body;
      n_slots[b] = 0;
    end
    n = n_slots[b];
    if (r.cmd == CMD_INSTALL) begin
      if (n < NSLOT) n++;
      n_slots[b] = n;
      for (int j = n - 1; j > 0; j--) lists[b][j] = lists[b][j-1];
      lists[b][0] = '{half: r.half, mid: r.mid, rec: r.rec, seg: r.seg};
      a.seg = r.seg;
      a.rec = r.rec;
      return a;
    end
    for (int i = 0; i < n; i++) begin
      if (in_range(r.qtime, lists[b][i].mid, lists[b][i].half)) begin
        s = lists[b][i];
        for (int j = i; j > 0; j--) lists[b][j] = lists[b][j-1];
        lists[b][0] = s;
        a.hit = 1'b1;
        a.seg = s.seg;
        a.rec = s.rec;
        return a;
      end
    end
    return a;
  endfunction

  // Directed rows; known answers only where obvious, else predictor.
  typedef struct {
    request_t req;
    bit       known;
    answer_t  ans;
  } row_t;

  row_t rows[$];

  function automatic request_t mk(input logic c, input logic [31:0] b, input logic [63:0] q,
                                  input logic [15:0] s, input logic [23:0] rc,
                                  input logic [63:0] m, input logic [62:0] h);
    request_t r;
    r = '{c, b, q, s, rc, m, h};
    return r;
  endfunction

  task automatic add_row(input request_t r, input bit k, input answer_t a);
    row_t w;
    w.req = r;
    w.known = k;
    w.ans = a;
    rows.push_back(w);
  endtask

  // Holds the transfer until it is taken; tvalid stays high for the caller.
  task automatic send(input request_t r);
    in_tdata <= {r.half, r.mid, r.rec, r.seg, r.qtime, r.body, r.cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (r.cmd == CMD_INSTALL) n_installs++;
    else n_lookups++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Random request biased toward few bodies and times near cached records.
  function automatic request_t random_request(input logic [31:0] bodies[6],
                                              input logic [63:0] centers[6]);
    request_t r;
    int       k;
    k = $urandom_range(0, 5);
    r.cmd = ($urandom_range(0, 2) == 0) ? CMD_INSTALL : CMD_LOOKUP;
    r.body = ($urandom_range(0, 9) == 0) ? $urandom() : bodies[$urandom_range(0, 5)];
    r.seg = 16'($urandom());
    r.rec = 24'($urandom());
    case ($urandom_range(0, 3))
      0: begin
        r.mid = rnd64();
        r.half = 63'(rnd64());
        r.qtime = rnd64();
      end
      default: begin
        r.mid = centers[k] + 64'($signed($urandom_range(0, 2000)) - 1000);
        r.half = 63'($urandom_range(0, 600));
        r.qtime = centers[k] + 64'($signed($urandom_range(0, 2000)) - 1000);
      end
    endcase
    return r;
  endfunction

  // Result receiver with its own stall pattern.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else begin
      cycles++;
      if (out_tvalid && out_tready) begin
        answer_t w;
        n_answers++;
        if (expected_answers.size() == 0) begin
          $display("unexpected result %h", out_tdata);
          errors++;
        end else begin
          w = expected_answers.pop_front();
          if (out_tdata[0] !== w.hit) report("hit", 64'(out_tdata[0]), 64'(w.hit));
          if (out_tdata[16:1] !== w.seg)
            report("segment_handle", 64'(out_tdata[16:1]), 64'(w.seg));
          if (out_tdata[40:17] !== w.rec)
            report("record_index", 64'(out_tdata[40:17]), 64'(w.rec));
          if (w.hit) n_hits++;
        end
      end
      out_tready <= (cycles % 600 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] bodies[6];
    logic [63:0] centers[6];
    answer_t     a;
    answer_t     miss;
    request_t    r;
    int          burst;
    errors = 0;
    cycles = 0;
    n_bodies = 0;
    n_hits = 0;
    n_installs = 0;
    n_lookups = 0;
    n_answers = 0;
    for (int i = 0; i < NBODY; i++) n_slots[i] = 0;
    miss = '{1'b0, 16'h0, 24'h0};

    // Lookups after reset, extremes and overflow of the list.
    add_row(mk(CMD_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0000, '0, '0, '0, '0), 1, miss);
    add_row(mk(CMD_INSTALL, 32'h7FFF_FFFF, '0, 16'hFFFF, 24'hFFFFFF,
               64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF), 1,
            '{1'b0, 16'hFFFF, 24'hFFFFFF});
    add_row(mk(CMD_LOOKUP, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000, '0, '0, '0, '0), 0, miss);
    add_row(mk(CMD_LOOKUP, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, '0), 0, miss);
    add_row(mk(CMD_INSTALL, 32'h8000_0000, '0, 16'h0, 24'h0,
               64'h8000_0000_0000_0000, 63'h0), 1, miss);
    add_row(mk(CMD_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0000, '0, '0, '0, '0), 0, miss);
    add_row(mk(CMD_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0001, '0, '0, '0, '0), 0, miss);
    for (int i = 0; i < 10; i++)
      add_row(mk(CMD_INSTALL, 32'd5, '0, 16'(i + 1), 24'(i + 100),
                 64'(i * 100), 63'd60), 1, '{1'b0, 16'(i + 1), 24'(i + 100)});
    add_row(mk(CMD_LOOKUP, 32'd5, 64'd50, '0, '0, '0, '0), 0, miss);
    add_row(mk(CMD_LOOKUP, 32'd5, 64'd200, '0, '0, '0, '0), 0, miss);
    add_row(mk(CMD_LOOKUP, 32'd5, 64'd340, '0, '0, '0, '0), 0, miss);
    for (int i = 0; i < 3; i++)
      add_row(mk(CMD_INSTALL, 32'(1000 + i), '0, 16'h1, 24'h2, '0, '0), 0, miss);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      a = predict_cache(rows[i].req);
      if (rows[i].known && a != rows[i].ans) begin
        $display("table row %0d disagrees with predictor", i);
        errors++;
      end
      expected_answers.push_back(rows[i].known ? rows[i].ans : a);
      send(rows[i].req);
    end
    // Fill the body table past capacity so the last entry is recycled.
    for (int i = 0; i < 20; i++) begin
      r = mk(CMD_INSTALL, 32'(2000 + i), '0, 16'(i), 24'(i), 64'(i), 63'd1);
      expected_answers.push_back(predict_cache(r));
      send(r);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 6; i++) begin
      bodies[i] = $urandom();
      centers[i] = rnd64();
    end
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
        r = random_request(bodies, centers);
        expected_answers.push_back(predict_cache(r));
        send(r);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      if ($urandom_range(0, 60) == 0) bodies[$urandom_range(0, 5)] = $urandom();
    end
    in_tvalid <= 1'b0;

    while (expected_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d lookups (%0d hits) and %0d installs over %0d results.",
             n_lookups, n_hits, n_installs, n_answers);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/irlc_pkg.sv
hdl/irlc_ram.sv
hdl/interval_record_lru_cache.sv
hdl/irlc_checker.sv
tb/tb_interval_record_lru_cache.sv
